/* hw/rtl/fasmd_pkg.sv */
// Shared types, constants and helper functions of the floating-point arithmetic unit.
`timescale 1ns / 1ps

package fasmd_pkg;

  localparam int FRAC_F = 23;
  localparam int FRAC_H = 10;
  localparam int BIAS_F = 127;
  localparam int BIAS_H = 15;
  localparam int EMAX_F = 255;
  localparam int EMAX_H = 31;

  localparam logic [FRAC_F-1:0] MASK_F = 23'h7FFFFF;
  localparam logic [FRAC_H-1:0] MASK_H = 10'h3FF;

  localparam int EW    = 12;          // signed exponent width
  localparam int SIG_W = FRAC_F + 1;  // significand with hidden bit
  localparam int ACC_W = 64;

  localparam logic [31:0] QNAN_F = 32'h7FC00000;
  localparam logic [31:0] QNAN_H = 32'h00007E00;

  // Biased exponent of the accumulator value once its leading one sits at bit 62.
  localparam logic signed [EW-1:0] ADD_OFS_F = EW'(30 - FRAC_F + BIAS_F);
  localparam logic signed [EW-1:0] ADD_OFS_H = EW'(30 - FRAC_H + BIAS_H);
  localparam logic signed [EW-1:0] MUL_OFS_F = EW'(62 - 2 * FRAC_F + BIAS_F);
  localparam logic signed [EW-1:0] MUL_OFS_H = EW'(62 - 2 * FRAC_H + BIAS_H);
  localparam logic signed [EW-1:0] DIV_OFS_F = EW'(23 + BIAS_F);
  localparam logic signed [EW-1:0] DIV_OFS_H = EW'(23 + BIAS_H);

  localparam logic signed [EW-1:0] EMAX_F_E = EW'(EMAX_F);
  localparam logic signed [EW-1:0] EMAX_H_E = EW'(EMAX_H);
  localparam logic signed [EW-1:0] EMIN_F_E = EW'(1 - BIAS_F);
  localparam logic signed [EW-1:0] EMIN_H_E = EW'(1 - BIAS_H);
  localparam logic signed [EW-1:0] BIAS_F_E = EW'(BIAS_F);
  localparam logic signed [EW-1:0] BIAS_H_E = EW'(BIAS_H);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] RM_RZ  = 2'd0;
  localparam logic [1:0] RM_RNE = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;

  localparam logic REG_FMT = 1'b0;
  localparam logic REG_RM  = 1'b1;

  typedef enum logic [1:0] {
    K_FIN  = 2'd0,
    K_ZERO = 2'd1,
    K_INF  = 2'd2,
    K_NAN  = 2'd3
  } kind_e;

  typedef struct packed {
    logic                  sign;
    kind_e                 kind;
    logic signed [EW-1:0]  exp;
    logic [SIG_W-1:0]      sig;
  } operand_t;

  typedef struct packed {
    logic [31:0] bits;
    kind_e       cls;
  } res_t;

  function automatic res_t special_res(logic sign, kind_e kind, logic fmt);
    res_t r;
    r.cls = kind;
    case (kind)
      K_NAN:   r.bits = fmt ? QNAN_H : QNAN_F;
      K_INF:   r.bits = fmt ? {16'b0, sign, 5'h1F, 10'b0} : {sign, 8'hFF, 23'b0};
      default: r.bits = fmt ? {16'b0, sign, 15'b0} : {sign, 31'b0};
    endcase
    return r;
  endfunction

  function automatic res_t ovf_res(logic sign, logic fmt, logic [1:0] rm);
    res_t r;
    logic to_inf;
    to_inf = (rm == RM_RNE) || (rm == RM_RUP && !sign) || (rm == RM_RDN && sign);
    if (to_inf) begin
      r = special_res(sign, K_INF, fmt);
    end else begin
      r.cls  = K_FIN;
      r.bits = fmt ? {16'b0, sign, 15'h7BFF} : {sign, 31'h7F7FFFFF};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fasmd_unpack.sv */
// Operand decoder: sign, class, unbiased exponent and significand of one encoding.
`timescale 1ns / 1ps

module fasmd_unpack
  import fasmd_pkg::*;
(
  input  logic [31:0] raw_i,
  input  logic        fmt_i,
  output operand_t    op_o
);

  logic [7:0]        ef;
  logic [7:0]        emax;
  logic [FRAC_F-1:0] frac;

  always_comb begin
    ef   = fmt_i ? {3'b0, raw_i[14:10]} : raw_i[30:23];
    emax = fmt_i ? 8'(EMAX_H) : 8'(EMAX_F);
    frac = fmt_i ? {13'b0, raw_i[9:0] & MASK_H} : (raw_i[22:0] & MASK_F);
    op_o.sign = fmt_i ? raw_i[15] : raw_i[31];
    if (ef == emax) begin
      op_o.kind = (frac != '0) ? K_NAN : K_INF;
    end else if (ef == 8'd0) begin
      op_o.kind = (frac == '0) ? K_ZERO : K_FIN;
    end else begin
      op_o.kind = K_FIN;
    end
    if (ef == 8'd0) begin
      op_o.exp = fmt_i ? EMIN_H_E : EMIN_F_E;
      op_o.sig = {1'b0, frac};
    end else begin
      op_o.exp = $signed({4'b0, ef}) - (fmt_i ? BIAS_H_E : BIAS_F_E);
      op_o.sig = fmt_i ? {13'b0, 1'b1, frac[FRAC_H-1:0]} : {1'b1, frac};
    end
  end

endmodule

/* hw/rtl/fasmd_round.sv */
// Final rounder: rounds the normalized accumulator and packs the encoding.
`timescale 1ns / 1ps

module fasmd_round
  import fasmd_pkg::*;
(
  input  logic [ACC_W-1:0]    acc_i,
  input  logic signed [EW-1:0] be_i,
  input  logic                sign_i,
  input  logic                fmt_i,
  input  logic [1:0]          rm_i,
  output res_t                res_o
);

  logic [SIG_W-1:0] kept;
  logic             half;
  logic             low;
  logic             inc;
  logic [7:0]       bexp;
  logic [31:0]      mag;
  logic [31:0]      lim;

  always_comb begin
    kept = fmt_i ? {13'b0, acc_i[62:52]} : acc_i[62:39];
    half = fmt_i ? acc_i[51] : acc_i[38];
    low  = fmt_i ? (|acc_i[50:0]) : (|acc_i[37:0]);
    case (rm_i)
      RM_RNE:  inc = half && (low || kept[0]);
      RM_RUP:  inc = (half || low) && !sign_i;
      RM_RDN:  inc = (half || low) && sign_i;
      default: inc = 1'b0;
    endcase
    bexp = be_i[7:0] - 8'd1;
    mag  = (fmt_i ? ({24'b0, bexp} << FRAC_H) : ({24'b0, bexp} << FRAC_F))
           + {8'b0, kept} + {31'b0, inc};
    lim  = fmt_i ? (32'(EMAX_H) << FRAC_H) : (32'(EMAX_F) << FRAC_F);
    if (mag >= lim) begin
      res_o = ovf_res(sign_i, fmt_i, rm_i);
    end else begin
      res_o.bits = fmt_i ? {16'b0, sign_i, mag[14:0]} : {sign_i, mag[30:0]};
      res_o.cls  = (mag == '0) ? K_ZERO : K_FIN;
    end
  end

endmodule

/* hw/rtl/float_add_sub_mul_div.sv */
// Top level: IEEE binary32/binary16 add, subtract, multiply and divide with a sequencer.
`timescale 1ns / 1ps

// Iterative IEEE 754 unit for binary32 or binary16 (number_format register) with
// four rounding modes. Pulse start_i while busy_o is low to issue one command; the
// result appears on result_bits_o / result_class_o, marked by valid_o for exactly one
// cycle, and must be taken then: the receiver cannot stall the unit. Special cases (a
// NaN or infinity operand, a zero in multiply or divide, or two zero addends) finish
// in the cycle after start and keep busy_o low. Otherwise a significand pass first
// shifts subnormal operands up to the hidden bit; then add/subtract aligns the smaller
// addend (exponent difference capped at 63) in steps of eight bits, then single bits,
// and adds, multiply forms the product, and divide runs a restoring divider, one
// quotient bit per cycle. A normalize pass follows, then an overflow check, an
// optional subnormal right-shift pass and a rounding step.
// Write configuration only while busy_o is low and no result is pending.

module float_add_sub_mul_div
  import fasmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        valid_o,
  output logic [31:0] result_bits_o,
  output logic [1:0]  result_class_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_ALIGN,
    S_ADDSUB,
    S_MUL,
    S_DIV,
    S_LNORM,
    S_DENORM,
    S_ROUND
  } state_e;

  state_e state_q, state_d;

  logic                 fmt_q, fmt_d;
  logic [1:0]           rm_q, rm_d;
  logic [1:0]           cmd_q, cmd_d;
  logic                 sign_a_q, sign_a_d, sign_b_q, sign_b_d, rsign_q, rsign_d;
  logic signed [EW-1:0] exp_a_q, exp_a_d, exp_b_q, exp_b_d, be_q, be_d;
  logic [SIG_W-1:0]     sig_a_q, sig_a_d, sig_b_q, sig_b_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [SIG_W:0]       rem_q, rem_d;
  logic [5:0]           cnt_q, cnt_d;
  logic                 valid_q, valid_d;
  logic [31:0]          bits_q, bits_d;
  kind_e                cls_q, cls_d;

  operand_t         ua, ub;
  res_t             sp, rnd;
  res_t             done_res;
  logic             sp_hit;
  logic             bsign;
  logic             s_xor;
  logic [4:0]       hb;
  logic             need_a, need_b;
  logic             swap;
  logic signed [EW-1:0] ediff;
  logic [ACC_W-1:0] xval;
  logic [47:0]      prod;
  logic             ge;
  logic [SIG_W:0]   r2;

  fasmd_unpack u_unpack_a (.raw_i(operand_a_i), .fmt_i(fmt_q), .op_o(ua));
  fasmd_unpack u_unpack_b (.raw_i(operand_b_i), .fmt_i(fmt_q), .op_o(ub));

  fasmd_round u_round (
    .acc_i (acc_q),
    .be_i  (be_q),
    .sign_i(rsign_q),
    .fmt_i (fmt_q),
    .rm_i  (rm_q),
    .res_o (rnd)
  );

  // Special operands settle the answer at issue time.
  always_comb begin
    bsign  = ub.sign ^ (command_i == CMD_SUB);
    s_xor  = ua.sign ^ ub.sign;
    sp_hit = 1'b1;
    sp     = special_res(1'b0, K_NAN, fmt_q);
    if (ua.kind == K_NAN || ub.kind == K_NAN) begin
      sp = special_res(1'b0, K_NAN, fmt_q);
    end else begin
      case (command_i)
        CMD_ADD, CMD_SUB: begin
          if (ua.kind == K_INF && ub.kind == K_INF) begin
            sp = special_res(ua.sign, (ua.sign == bsign) ? K_INF : K_NAN, fmt_q);
          end else if (ua.kind == K_INF) begin
            sp = special_res(ua.sign, K_INF, fmt_q);
          end else if (ub.kind == K_INF) begin
            sp = special_res(bsign, K_INF, fmt_q);
          end else if (ua.kind == K_ZERO && ub.kind == K_ZERO) begin
            sp = special_res((ua.sign == bsign) ? ua.sign : (rm_q == RM_RDN), K_ZERO,
                             fmt_q);
          end else begin
            sp_hit = 1'b0;
          end
        end
        CMD_MUL: begin
          if ((ua.kind == K_INF && ub.kind == K_ZERO) ||
              (ua.kind == K_ZERO && ub.kind == K_INF)) begin
            sp = special_res(1'b0, K_NAN, fmt_q);
          end else if (ua.kind == K_INF || ub.kind == K_INF) begin
            sp = special_res(s_xor, K_INF, fmt_q);
          end else if (ua.kind == K_ZERO || ub.kind == K_ZERO) begin
            sp = special_res(s_xor, K_ZERO, fmt_q);
          end else begin
            sp_hit = 1'b0;
          end
        end
        default: begin
          if ((ua.kind == K_INF && ub.kind == K_INF) ||
              (ua.kind == K_ZERO && ub.kind == K_ZERO)) begin
            sp = special_res(1'b0, K_NAN, fmt_q);
          end else if (ua.kind == K_INF || ub.kind == K_ZERO) begin
            sp = special_res(s_xor, K_INF, fmt_q);
          end else if (ub.kind == K_INF || ua.kind == K_ZERO) begin
            sp = special_res(s_xor, K_ZERO, fmt_q);
          end else begin
            sp_hit = 1'b0;
          end
        end
      endcase
    end
  end

  assign hb     = fmt_q ? 5'(FRAC_H) : 5'(FRAC_F);
  assign need_a = (sig_a_q != '0) && !sig_a_q[hb];
  assign need_b = (sig_b_q != '0) && !sig_b_q[hb];
  assign swap   = (sig_a_q == '0) || ((sig_b_q != '0) && (exp_b_q > exp_a_q));
  assign ediff  = swap ? (exp_b_q - exp_a_q) : (exp_a_q - exp_b_q);
  assign xval   = {8'b0, sig_a_q, 32'b0};
  assign prod   = 48'(sig_a_q) * 48'(sig_b_q);
  assign ge     = rem_q >= {1'b0, sig_b_q};
  assign r2     = ge ? (rem_q - {1'b0, sig_b_q}) : rem_q;

  always_comb begin
    state_d  = state_q;
    fmt_d    = fmt_q;
    rm_d     = rm_q;
    cmd_d    = cmd_q;
    sign_a_d = sign_a_q;
    sign_b_d = sign_b_q;
    rsign_d  = rsign_q;
    exp_a_d  = exp_a_q;
    exp_b_d  = exp_b_q;
    be_d     = be_q;
    sig_a_d  = sig_a_q;
    sig_b_d  = sig_b_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    bits_d   = bits_q;
    cls_d    = cls_q;
    done_res = rnd;

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_FMT) begin
        fmt_d = cfg_data_i[0];
      end else begin
        rm_d = cfg_data_i;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (sp_hit) begin
            bits_d  = sp.bits;
            cls_d   = sp.cls;
            valid_d = 1'b1;
          end else begin
            cmd_d    = command_i;
            sign_a_d = ua.sign;
            sign_b_d = bsign;
            exp_a_d  = ua.exp;
            exp_b_d  = ub.exp;
            sig_a_d  = (ua.kind == K_ZERO) ? '0 : ua.sig;
            sig_b_d  = (ub.kind == K_ZERO) ? '0 : ub.sig;
            state_d  = S_NORM;
          end
        end
      end
      // Bring subnormal significands up to the hidden bit, one bit a cycle.
      S_NORM: begin
        if (need_a) begin
          sig_a_d = {sig_a_q[SIG_W-2:0], 1'b0};
          exp_a_d = exp_a_q - EW'(1);
        end
        if (need_b) begin
          sig_b_d = {sig_b_q[SIG_W-2:0], 1'b0};
          exp_b_d = exp_b_q - EW'(1);
        end
        if (!need_a && !need_b) begin
          case (cmd_q)
            CMD_ADD, CMD_SUB: begin
              if (swap) begin
                sig_a_d  = sig_b_q;
                exp_a_d  = exp_b_q;
                sign_a_d = sign_b_q;
                sign_b_d = sign_a_q;
                acc_d    = {8'b0, sig_a_q, 32'b0};
              end else begin
                acc_d    = {8'b0, sig_b_q, 32'b0};
              end
              cnt_d   = (ediff > EW'(63)) ? 6'd63 : ediff[5:0];
              state_d = S_ALIGN;
            end
            CMD_MUL: state_d = S_MUL;
            default: begin
              rem_d   = {1'b0, sig_a_q};
              acc_d   = '0;
              cnt_d   = 6'd39;
              state_d = S_DIV;
            end
          endcase
        end
      end
      // Right-shift the smaller addend, folding lost bits into bit 0.
      S_ALIGN: begin
        if (cnt_q >= 6'd8) begin
          acc_d = {8'b0, acc_q[ACC_W-1:8]} | {63'b0, |acc_q[7:0]};
          cnt_d = cnt_q - 6'd8;
        end else if (cnt_q != '0) begin
          acc_d = {1'b0, acc_q[ACC_W-1:1]} | {63'b0, acc_q[0]};
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = S_ADDSUB;
        end
      end
      S_ADDSUB: begin
        be_d    = exp_a_q + (fmt_q ? ADD_OFS_H : ADD_OFS_F);
        state_d = S_LNORM;
        if (sign_a_q == sign_b_q) begin
          acc_d   = xval + acc_q;
          rsign_d = sign_a_q;
        end else if (xval > acc_q) begin
          acc_d   = xval - acc_q;
          rsign_d = sign_a_q;
        end else if (acc_q > xval) begin
          acc_d   = acc_q - xval;
          rsign_d = sign_b_q;
        end else begin
          // Exact cancellation: signed zero by rounding direction.
          done_res = special_res(rm_q == RM_RDN, K_ZERO, fmt_q);
          bits_d   = done_res.bits;
          cls_d    = done_res.cls;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_MUL: begin
        acc_d   = {16'b0, prod};
        be_d    = exp_a_q + exp_b_q + (fmt_q ? MUL_OFS_H : MUL_OFS_F);
        rsign_d = sign_a_q ^ sign_b_q;
        state_d = S_LNORM;
      end
      // Restoring division: one quotient bit per cycle, sticky from the remainder.
      S_DIV: begin
        acc_d = {acc_q[ACC_W-2:0], ge};
        rem_d = {r2[SIG_W-1:0], 1'b0};
        if (cnt_q == '0) begin
          acc_d   = {acc_q[ACC_W-2:0], ge | (r2 != '0)};
          be_d    = exp_a_q - exp_b_q + (fmt_q ? DIV_OFS_H : DIV_OFS_F);
          rsign_d = sign_a_q ^ sign_b_q;
          state_d = S_LNORM;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      // Left-normalize until the leading one sits at bit 62.
      S_LNORM: begin
        if (acc_q[62]) begin
          state_d = S_DENORM;
        end else if (acc_q[62:55] == 8'b0) begin
          acc_d = {acc_q[ACC_W-9:0], 8'b0};
          be_d  = be_q - EW'(8);
        end else begin
          acc_d = {acc_q[ACC_W-2:0], 1'b0};
          be_d  = be_q - EW'(1);
        end
      end
      // Catch overflow, then walk tiny results down to the subnormal quantum.
      S_DENORM: begin
        if (be_q >= (fmt_q ? EMAX_H_E : EMAX_F_E)) begin
          done_res = ovf_res(rsign_q, fmt_q, rm_q);
          bits_d   = done_res.bits;
          cls_d    = done_res.cls;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else if (be_q < EW'(1)) begin
          if (acc_q[ACC_W-1:1] == '0) begin
            be_d = EW'(1);
          end else if (be_q <= -EW'(7)) begin
            acc_d = {8'b0, acc_q[ACC_W-1:8]} | {63'b0, |acc_q[7:0]};
            be_d  = be_q + EW'(8);
          end else begin
            acc_d = {1'b0, acc_q[ACC_W-1:1]} | {63'b0, acc_q[0]};
            be_d  = be_q + EW'(1);
          end
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        bits_d  = rnd.bits;
        cls_d   = rnd.cls;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fmt_q    <= 1'b0;
      rm_q     <= RM_RZ;
      cmd_q    <= CMD_ADD;
      sign_a_q <= 1'b0;
      sign_b_q <= 1'b0;
      rsign_q  <= 1'b0;
      exp_a_q  <= '0;
      exp_b_q  <= '0;
      be_q     <= '0;
      sig_a_q  <= '0;
      sig_b_q  <= '0;
      acc_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      bits_q   <= '0;
      cls_q    <= K_FIN;
    end else begin
      state_q  <= state_d;
      fmt_q    <= fmt_d;
      rm_q     <= rm_d;
      cmd_q    <= cmd_d;
      sign_a_q <= sign_a_d;
      sign_b_q <= sign_b_d;
      rsign_q  <= rsign_d;
      exp_a_q  <= exp_a_d;
      exp_b_q  <= exp_b_d;
      be_q     <= be_d;
      sig_a_q  <= sig_a_d;
      sig_b_q  <= sig_b_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
      bits_q   <= bits_d;
      cls_q    <= cls_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign result_bits_o  = bits_q;
  assign result_class_o = cls_q;

`ifndef SYNTHESIS
  a_beat_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result beat while busy");
  a_nan_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_class_o == K_NAN) |-> (result_bits_o == (fmt_q ? QNAN_H : QNAN_F)))
    else $error("non-canonical NaN");
  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && fmt_q) |-> (result_bits_o[31:16] == 16'b0))
    else $error("binary16 result has upper bits set");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (be_q >= EW'(1) && be_q < (fmt_q ? EMAX_H_E : EMAX_F_E)))
    else $error("rounding exponent out of range");
`endif

endmodule

/* bench/tb_float_add_sub_mul_div.sv */
// Self-checking bench for the binary32/binary16 add, subtract, multiply and divide unit.
`timescale 1ns / 1ps

module tb_float_add_sub_mul_div;
  import fasmd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_FMT;
  logic [1:0]  cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CMD_ADD;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        valid_o;
  logic [31:0] result_bits_o;
  logic [1:0]  result_class_o;

  float_add_sub_mul_div DUT (.*);

  always #2 clk_i = ~clk_i;

  // Predictor copy of the two registers.
  logic       fmt_q = 1'b0;
  logic [1:0] rm_q  = RM_RZ;

  res_t expected_q[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   gap_pct = 0;

  // Sign, kind, unbiased exponent and significand of one operand.
  typedef struct {
    logic        sign;
    kind_e       kind;
    int          e;
    logic [63:0] sig;
  } fp_t;

  function automatic int frac_w();
    return fmt_q ? FRAC_H : FRAC_F;
  endfunction

  function automatic int emax_w();
    return fmt_q ? EMAX_H : EMAX_F;
  endfunction

  function automatic int sign_at();
    return fmt_q ? 15 : 31;
  endfunction

  function automatic fp_t decode(logic [31:0] raw);
    fp_t o;
    int m, ef;
    logic [63:0] f;
    m = frac_w();
    if (fmt_q) raw = {16'b0, raw[15:0]};
    o.sign = raw[sign_at()];
    ef = (raw >> m) & emax_w();
    f = raw & ((64'd1 << m) - 1);
    o.e = 0;
    o.sig = 0;
    if (ef == emax_w()) begin
      o.kind = (f != 0) ? K_NAN : K_INF;
    end else if (ef == 0) begin
      if (f == 0) begin
        o.kind = K_ZERO;
      end else begin
        o.kind = K_FIN;
        o.e = 1 - (fmt_q ? BIAS_H : BIAS_F);
        while (f[m] == 1'b0) begin
          f = f << 1;
          o.e--;
        end
        o.sig = f;
      end
    end else begin
      o.kind = K_FIN;
      o.e = ef - (fmt_q ? BIAS_H : BIAS_F);
      o.sig = f | (64'd1 << m);
    end
    return o;
  endfunction

  function automatic res_t special(logic sign, kind_e kind);
    res_t r;
    r.cls = kind;
    if (kind == K_NAN) r.bits = fmt_q ? QNAN_H : QNAN_F;
    else r.bits = (32'(sign) << sign_at()) |
                  ((kind == K_INF) ? (32'(emax_w()) << frac_w()) : 32'd0);
    return r;
  endfunction

  function automatic res_t overflowed(logic sign);
    res_t r;
    if (rm_q == RM_RNE || (rm_q == RM_RUP && !sign) || (rm_q == RM_RDN && sign))
      return special(sign, K_INF);
    r.cls = K_FIN;
    r.bits = (32'(sign) << sign_at()) | ((32'(emax_w()) << frac_w()) - 1);
    return r;
  endfunction

  // Round the nonzero value sig * 2^e2 once, sticky already in the low bits.
  function automatic res_t round_value(logic sign, int e2, logic [63:0] sig);
    res_t r;
    int m, be, s;
    logic [63:0] kept, rem, half, mag;
    logic above, tie, inexact, inc;
    m = frac_w();
    while (sig[63:62] == 2'b00) begin
      sig = sig << 1;
      e2--;
    end
    be = e2 + 62 + (fmt_q ? BIAS_H : BIAS_F);
    if (be >= emax_w()) return overflowed(sign);
    s = (be >= 1) ? 62 - m : 62 - m + (1 - be);
    if (s > 64) s = 64;
    if (s >= 64) begin
      kept = 0; above = 0; tie = 0; inexact = 1;
    end else begin
      kept = sig >> s;
      rem = sig & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      above = rem > half;
      tie = rem == half;
      inexact = rem != 0;
    end
    case (rm_q)
      RM_RNE:  inc = above || (tie && kept[0]);
      RM_RUP:  inc = inexact && !sign;
      RM_RDN:  inc = inexact && sign;
      default: inc = 1'b0;
    endcase
    kept = kept + 64'(inc);
    mag = ((be >= 1) ? (64'(be - 1) << m) : 64'd0) + kept;
    if (mag >= (64'(emax_w()) << m)) return overflowed(sign);
    r.bits = (32'(sign) << sign_at()) | mag[31:0];
    r.cls = (mag != 0) ? K_FIN : K_ZERO;
    return r;
  endfunction

  function automatic res_t sum_of(fp_t a, fp_t b);
    fp_t big, sml;
    logic [63:0] x, y, lost;
    int d, m;
    m = frac_w();
    if (a.kind == K_INF || b.kind == K_INF) begin
      if (a.kind == K_INF && b.kind == K_INF)
        return special(a.sign, (a.sign == b.sign) ? K_INF : K_NAN);
      return special((a.kind == K_INF) ? a.sign : b.sign, K_INF);
    end
    if (a.kind == K_ZERO && b.kind == K_ZERO)
      return special((a.sign == b.sign) ? a.sign : (rm_q == RM_RDN), K_ZERO);
    if (a.kind == K_ZERO) return round_value(b.sign, b.e - m, b.sig);
    if (b.kind == K_ZERO) return round_value(a.sign, a.e - m, a.sig);
    if (a.e >= b.e) begin big = a; sml = b; end
    else begin big = b; sml = a; end
    x = big.sig << 32;
    y = sml.sig << 32;
    d = big.e - sml.e;
    if (d >= 63) begin
      y = 1;
    end else begin
      lost = y & ((64'd1 << d) - 1);
      y = y >> d;
      if (lost != 0) y[0] = 1'b1;
    end
    if (big.sign == sml.sign) return round_value(big.sign, big.e - m - 32, x + y);
    if (x > y) return round_value(big.sign, big.e - m - 32, x - y);
    if (y > x) return round_value(sml.sign, big.e - m - 32, y - x);
    return special(rm_q == RM_RDN, K_ZERO);
  endfunction

  function automatic res_t predict_result(logic [1:0] cmd, logic [31:0] ra, logic [31:0] rb);
    fp_t a, b;
    logic s;
    logic [63:0] num, q;
    int m;
    m = frac_w();
    a = decode(ra);
    b = decode(rb);
    s = a.sign ^ b.sign;
    if (a.kind == K_NAN || b.kind == K_NAN) return special(1'b0, K_NAN);
    case (cmd)
      CMD_ADD: return sum_of(a, b);
      CMD_SUB: begin
        b.sign = ~b.sign;
        return sum_of(a, b);
      end
      CMD_MUL: begin
        if ((a.kind == K_INF && b.kind == K_ZERO) || (a.kind == K_ZERO && b.kind == K_INF))
          return special(1'b0, K_NAN);
        if (a.kind == K_INF || b.kind == K_INF) return special(s, K_INF);
        if (a.kind == K_ZERO || b.kind == K_ZERO) return special(s, K_ZERO);
        return round_value(s, a.e + b.e - 2 * m, a.sig * b.sig);
      end
      default: begin
        if ((a.kind == K_INF && b.kind == K_INF) || (a.kind == K_ZERO && b.kind == K_ZERO))
          return special(1'b0, K_NAN);
        if (a.kind == K_INF || b.kind == K_ZERO) return special(s, K_INF);
        if (b.kind == K_INF || a.kind == K_ZERO) return special(s, K_ZERO);
        num = a.sig << 39;
        q = num / b.sig;
        if (num % b.sig != 0) q[0] = 1'b1;
        return round_value(s, a.e - b.e - 39, q);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Check each result beat against the oldest pending prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result_bits_o, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (result_bits_o !== want.bits) report_mismatch("result_bits", result_bits_o, want.bits);
        if (result_class_o !== want.cls)
          report_mismatch("result_class", 32'(result_class_o), 32'(want.cls));
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_float_add_sub_mul_div failed");
      $finish;
    end
  end

  // Issue one command beat; hold start until the unit takes it. Start stays high
  // after the accepting edge until the next beat or an idle cycle replaces it.
  task automatic send_op(logic [1:0] cmd, logic [31:0] a, logic [31:0] b);
    while (($urandom_range(99) < gap_pct)) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    command_i   <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.push_back(predict_result(cmd, a, b));
  endtask

  // Drop start, drain outstanding results, then let the unit settle.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [1:0] val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FMT) fmt_q = val[0];
    else rm_q = val;
  endtask

  // Encodings biased toward the interesting corners of the chosen format.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    logic [31:0] e;
    v = $urandom;
    e = $urandom_range(9);
    if (fmt_q) begin
      case (e)
        0: v[14:10] = 5'h00;
        1: v[14:10] = 5'h1F;
        2: v[14:0]  = {5'h1F, 10'h0};
        3: v[14:0]  = 15'h0;
        4: v[14:10] = 5'($urandom_range(30, 27));
        5: v[14:10] = 5'($urandom_range(3, 1));
        default: ;
      endcase
    end else begin
      case (e)
        0: v[30:23] = 8'h00;
        1: v[30:23] = 8'hFF;
        2: v[30:0]  = {8'hFF, 23'h0};
        3: v[30:0]  = 31'h0;
        4: v[30:23] = 8'($urandom_range(254, 240));
        5: v[30:23] = 8'($urandom_range(12, 1));
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic test_directed();
    logic [31:0] f32[12] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                             32'h7FC00001, 32'h00000001, 32'h007FFFFF, 32'h7F7FFFFF,
                             32'h3F800000, 32'hBF800000, 32'h00800000, 32'hFFFFFFFF};
    logic [31:0] f16[8]  = '{32'hFFFF0000, 32'h00008000, 32'h00007C00, 32'h0000FC00,
                             32'h00000001, 32'h00007BFF, 32'h12343C00, 32'h00007D01};
    for (int i = 0; i < 12; i++) send_op(2'(i), f32[i], f32[(i * 5 + 3) % 12]);
    send_op(CMD_SUB, 32'h7F800000, 32'h7F800000);
    send_op(CMD_MUL, 32'h00000000, 32'hFF800000);
    send_op(CMD_DIV, 32'h00000000, 32'h80000000);
    send_op(CMD_DIV, 32'h7F800000, 32'hFF800000);
    send_op(CMD_DIV, 32'hC0000000, 32'h00000000);
    send_op(CMD_SUB, 32'h3F800000, 32'h3F800000);
    send_op(CMD_MUL, 32'h7F7FFFFF, 32'h7F7FFFFF);
    send_op(CMD_MUL, 32'h00000001, 32'h3E800000);
    write_cfg(REG_FMT, 2'd1);
    for (int i = 0; i < 8; i++) send_op(2'(i), f16[i], f16[7 - i]);
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) send_op(2'($urandom), pick_operand(), pick_operand());
  endtask

  // Sweep both formats and all rounding modes under one idling profile.
  task automatic test_phase(int gap);
    gap_pct = gap;
    for (int f = 0; f < 2; f++) begin
      write_cfg(REG_FMT, 2'(f));
      for (int r = 0; r < 4; r++) begin
        write_cfg(REG_RM, 2'(r));
        test_random(34);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 18;
    test_directed();
    write_cfg(REG_RM, RM_RNE);
    test_directed();
    test_phase(18);
    test_phase(77);
    test_phase(0);
    wait_idle();
    if (mismatches == 0) $display("tb_float_add_sub_mul_div passed");
    else $display("tb_float_add_sub_mul_div failed");
    $finish;
  end

endmodule
